// File: hdl/atc_pkg.sv
// Package for the 3x4 homogeneous transform composer: widths, payload structs.
// Depends on nothing; used by affine_transform_compose.
`timescale 1ns / 1ps
`default_nettype none

package atc_pkg;

  // Fixed-point format of stored elements and product elements
  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;

  // Matrix geometry: 3 rows by 4 columns, index row*4+col
  localparam int MAT_ENTRIES = 12;
  localparam int ADDR_W      = 4;

  // Full-precision product and a 3-term sum plus translation
  localparam int PROD_W = 2 * VALUE_WIDTH;
  localparam int ACC_W  = PROD_W + 2;

  typedef struct packed {
    logic                          target_matrix;
    logic [1:0]                    row_index;
    logic [1:0]                    col_index;
    logic signed [VALUE_WIDTH-1:0] element_value;
    logic                          compute_now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                    out_row;
    logic [1:0]                    out_col;
    logic signed [VALUE_WIDTH-1:0] product_value;
    logic                          end_of_product;
  } out_item_t;

endpackage

`default_nettype wire

// File: hdl/affine_transform_compose.sv
// Top level of the 3x4 homogeneous transform composer (P = A * B, implied 0,0,0,1 row).
// Depends on atc_pkg for widths and the payload structs.
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer writes one element of matrix A or B into a 12-entry memory
// (row index three is dropped). A transfer with compute_now set stores its element
// and then streams the 12 product elements in row-major order, end_of_product on the
// last. A compute runs one term per cycle, unless the output stalls, through a shared
// read port of each memory and one 32x32 multiplier: three terms per element, four on
// the translation column, 39 terms in all, each ending with the memory read. The product
// register, the accumulator and round and saturate bring the last result into the output
// register. Output stalls freeze the pipeline. A store-only item leaves in_ready high.
// The next item is taken as soon as the previous compute has issued its last term.
module affine_transform_compose (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire atc_pkg::in_item_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output atc_pkg::out_item_t  out_data
);

  localparam int VW  = atc_pkg::VALUE_WIDTH;
  localparam int FB  = atc_pkg::FRACTION_BITS;
  localparam int PW  = atc_pkg::PROD_W;
  localparam int AW  = atc_pkg::ACC_W;
  localparam int ADW = atc_pkg::ADDR_W;

  typedef enum logic {IDLE, RUN} state_t;

  // Per-term tags that travel with the data down the pipeline
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic       trans;
    logic [1:0] row;
    logic [1:0] col;
    logic       eop;
  } tag_t;

  // Matrix memories
  logic [VW-1:0] mem_a [atc_pkg::MAT_ENTRIES];
  logic [VW-1:0] mem_b [atc_pkg::MAT_ENTRIES];

  state_t     state_r;
  logic [1:0] row_r, col_r, term_r;

  logic                 adv;
  logic                 in_xfer, out_xfer;
  logic [ADW-1:0]       wr_addr, rd_addr_a, rd_addr_b;
  tag_t                 issue_tag;
  tag_t                 s1_tag_r, s2_tag_r, s3_tag_r;
  logic signed [VW-1:0] rd_a_r, rd_b_r;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt, shifted;
  logic [VW-1:0]        sat_val;
  logic                 last_term, last_elem;

  assign in_ready = (state_r == IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Pipeline moves unless a finished element cannot enter the output register
  assign adv = !(s3_tag_r.valid && s3_tag_r.last && out_valid && !out_ready);

  // Issue-side term decode
  assign last_term = (col_r == 2'd3) ? (term_r == 2'd3) : (term_r == 2'd2);
  assign last_elem = (row_r == 2'd2) && (col_r == 2'd3);
  assign rd_addr_a = {row_r, term_r};
  assign rd_addr_b = (term_r == 2'd3) ? {2'd0, col_r} : {term_r, col_r};
  assign wr_addr   = {in_data.row_index, in_data.col_index};

  always_comb begin
    issue_tag.valid = (state_r == RUN);
    issue_tag.first = (term_r == 2'd0);
    issue_tag.last  = last_term;
    issue_tag.trans = (term_r == 2'd3);
    issue_tag.row   = row_r;
    issue_tag.col   = col_r;
    issue_tag.eop   = last_elem;
  end

  // Sequencer: state and term counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      row_r   <= 2'd0;
      col_r   <= 2'd0;
      term_r  <= 2'd0;
    end else begin
      unique case (state_r)
        IDLE: begin
          if (in_xfer && in_data.compute_now) begin
            state_r <= RUN;
            row_r   <= 2'd0;
            col_r   <= 2'd0;
            term_r  <= 2'd0;
          end
        end
        RUN: begin
          if (adv) begin
            if (!last_term) begin
              term_r <= term_r + 2'd1;
            end else begin
              term_r <= 2'd0;
              if (last_elem) begin
                state_r <= IDLE;
              end else if (col_r == 2'd3) begin
                col_r <= 2'd0;
                row_r <= row_r + 2'd1;
              end else begin
                col_r <= col_r + 2'd1;
              end
            end
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  // Memory writes on input transfers; row three is dropped
  always_ff @(posedge clk) begin
    if (in_xfer && (in_data.row_index != 2'd3)) begin
      if (in_data.target_matrix) begin
        mem_b[wr_addr] <= in_data.element_value;
      end else begin
        mem_a[wr_addr] <= in_data.element_value;
      end
    end
  end

  // Registered memory reads
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_a_r <= mem_a[rd_addr_a];
      rd_b_r <= mem_b[rd_addr_b];
    end
  end

  // Multiply, or align the translation term to the product scale
  always_comb begin
    if (s1_tag_r.trans) begin
      prod_nxt = {{(VW-FB){rd_a_r[VW-1]}}, rd_a_r, {FB{1'b0}}};
    end else begin
      prod_nxt = rd_a_r * rd_b_r;
    end
  end

  // Accumulate at full precision
  assign acc_nxt = (s2_tag_r.first ? {AW{1'b0}} : acc_r)
                 + {{(AW-PW){prod_r[PW-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      if (s2_tag_r.valid) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // Tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
    end else if (adv) begin
      s1_tag_r <= issue_tag;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  // Arithmetic shift and saturation
  assign shifted = acc_r >>> FB;

  always_comb begin
    if ((&shifted[AW-1:VW-1]) || !(|shifted[AW-1:VW-1])) begin
      sat_val = shifted[VW-1:0];
    end else if (shifted[AW-1]) begin
      sat_val = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VW-1){1'b1}}};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv && s3_tag_r.valid && s3_tag_r.last) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_tag_r.valid && s3_tag_r.last) begin
      out_data.out_row        <= s3_tag_r.row;
      out_data.out_col        <= s3_tag_r.col;
      out_data.product_value  <= sat_val;
      out_data.end_of_product <= s3_tag_r.eop;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/affine_transform_compose_test.sv
// Self-checking testbench for affine_transform_compose (3x4 homogeneous transform product).
// Depends on atc_pkg for widths and payload structs, and on the affine_transform_compose RTL.
`timescale 1ns / 1ps

module affine_transform_compose_test;

  localparam int  VALUE_WIDTH    = atc_pkg::VALUE_WIDTH;
  localparam int  FRACTION_BITS  = atc_pkg::FRACTION_BITS;
  localparam int  ACC_W          = atc_pkg::ACC_W;
  localparam int  MAT_ENTRIES    = atc_pkg::MAT_ENTRIES;

  localparam int  TAIL_ITEMS     = 60;      // last stretch of the run has no idling
  localparam int  RANDOM_ITEMS   = 480;
  localparam int  HOLD_CYCLES    = 300;     // long output hold to back up the block
  localparam int  HOLD_AFTER     = 40;      // results seen before the hold starts
  localparam int  DRAIN_CYCLES   = 64;
  localparam int  TIMEOUT_NS     = 3_200_000;

  localparam logic signed [VALUE_WIDTH-1:0] Q_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] Q_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  atc_pkg::in_item_t  in_data  = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  atc_pkg::out_item_t out_data;

  affine_transform_compose u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copies of both matrices, index row*4+col
  logic signed [VALUE_WIDTH-1:0] mat_a [MAT_ENTRIES];
  logic signed [VALUE_WIDTH-1:0] mat_b [MAT_ENTRIES];

  atc_pkg::in_item_t  pending_elements [$];
  atc_pkg::out_item_t expected_products [$];

  int  n_items     = 0;
  int  n_accepted  = 0;
  int  n_results   = 0;
  int  n_computes  = 0;
  int  fail_count  = 0;
  int  gap_left    = 0;
  int  stall_left  = 0;
  bit  calm        = 1'b0;
  bit  hold_done   = 1'b0;

  // One product element: 3-term dot product plus translation on column 3,
  // floor shift by the fraction bits, then saturate
  function automatic logic signed [VALUE_WIDTH-1:0] compose_element(int r, int c);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] sh;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      x = mat_a[r*4+k];
      y = mat_b[k*4+c];
      acc = acc + x * y;
    end
    if (c == 3) begin
      x = mat_a[r*4+3];
      acc = acc + (x <<< FRACTION_BITS);
    end
    sh = acc >>> FRACTION_BITS;
    if (sh > SAT_HI) return Q_MAX;
    if (sh < SAT_LO) return Q_MIN;
    return sh[VALUE_WIDTH-1:0];
  endfunction

  // Store the element (row three is dropped), then queue the 12 products on compute
  task automatic absorb_element(input atc_pkg::in_item_t it);
    int idx;
    atc_pkg::out_item_t p;
    idx = int'(it.row_index) * 4 + int'(it.col_index);
    if (it.row_index < 2'd3) begin
      if (it.target_matrix) mat_b[idx] = it.element_value;
      else mat_a[idx] = it.element_value;
    end
    if (it.compute_now) begin
      n_computes++;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          p.out_row        = 2'(r);
          p.out_col        = 2'(c);
          p.product_value  = compose_element(r, c);
          p.end_of_product = (r == 2 && c == 3);
          expected_products.push_back(p);
        end
      end
    end
  endtask

  function automatic atc_pkg::in_item_t element_write(logic tgt, logic [1:0] row,
                                                      logic [1:0] col,
                                                      logic signed [VALUE_WIDTH-1:0] val,
                                                      logic cmp);
    atc_pkg::in_item_t it;
    it.target_matrix = tgt;
    it.row_index     = row;
    it.col_index     = col;
    it.element_value = val;
    it.compute_now   = cmp;
    return it;
  endfunction

  // Mix of full-range words, extremes and small Q16.16 values
  function automatic logic signed [VALUE_WIDTH-1:0] draw_element_value();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 6))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return '1;
          4: return 1;
          5: return 1 << FRACTION_BITS;
          default: return -(1 <<< FRACTION_BITS);
        endcase
      end
      default: return $urandom_range(0, 1 << 20) - (1 << 19);
    endcase
  endfunction

  function automatic logic [1:0] draw_row();
    if ($urandom_range(0, 15) == 0) return 2'd3;
    return 2'($urandom_range(0, 2));
  endfunction

  // Driver: one new item per free slot, random idle bursts outside the tail
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_elements.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else begin
        in_data  <= pending_elements.pop_front();
        in_valid <= 1'b1;
      end
    end
    calm <= (pending_elements.size() < TAIL_ITEMS);
  end

  // Receiver: random stall bursts plus one long hold while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!hold_done && n_results >= HOLD_AFTER) begin
      hold_done  <= 1'b1;
      stall_left <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on input transfer, check each output transfer in order
  always @(posedge clk) begin : monitor
    atc_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        absorb_element(in_data);
        n_accepted <= n_accepted + 1;
      end
      if (out_valid && out_ready) begin
        n_results <= n_results + 1;
        if (expected_products.size() == 0) begin
          $error("unexpected product element row %0d col %0d value %0d",
                 out_data.out_row, out_data.out_col, out_data.product_value);
          fail_count++;
        end else begin
          want = expected_products.pop_front();
          if (out_data.out_row !== want.out_row) begin
            $error("out_row: expected %0d, actual %0d", want.out_row, out_data.out_row);
            fail_count++;
          end
          if (out_data.out_col !== want.out_col) begin
            $error("out_col: expected %0d, actual %0d", want.out_col, out_data.out_col);
            fail_count++;
          end
          if (out_data.product_value !== want.product_value) begin
            $error("product_value: expected %0d, actual %0d (row %0d col %0d)",
                   want.product_value, out_data.product_value, want.out_row, want.out_col);
            fail_count++;
          end
          if (out_data.end_of_product !== want.end_of_product) begin
            $error("end_of_product: expected %0d, actual %0d",
                   want.end_of_product, out_data.end_of_product);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int       made;
    int       burst;
    logic     tgt;
    logic     cmp;

    // Directed: A row 0 at max, rows 1-2 at min, B all max; the compute on the
    // last write gives positive saturation on row 0 and negative on rows 1-2
    for (int t = 0; t < 2; t++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          cmp = (t == 1 && r == 2 && c == 3);
          pending_elements.push_back(element_write(t[0], 2'(r), 2'(c),
            (t == 1 || r == 0) ? Q_MAX : Q_MIN, cmp));
        end
      end
    end
    // Row index three: write dropped, product still emitted from the stores
    pending_elements.push_back(element_write(1'b1, 2'd3, 2'd3, 32'sh1234_5678, 1'b1));
    pending_elements.push_back(element_write(1'b0, 2'd3, 2'd0, Q_MIN, 1'b0));

    // Random: mostly write bursts closed by a compute, some full reloads, some noise
    made = 0;
    while (made < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          tgt = 1'($urandom_range(0, 1));
          for (int i = 0; i < MAT_ENTRIES; i++) begin
            pending_elements.push_back(element_write(tgt, 2'(i / 4), 2'(i % 4),
              draw_element_value(), i == MAT_ENTRIES - 1));
          end
          made += MAT_ENTRIES;
        end
        1, 2: begin
          pending_elements.push_back(element_write(1'($urandom_range(0, 1)),
            2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), draw_element_value(),
            $urandom_range(0, 3) == 0));
          made++;
        end
        default: begin
          burst = $urandom_range(1, 12);
          for (int i = 0; i < burst; i++) begin
            pending_elements.push_back(element_write(1'($urandom_range(0, 1)), draw_row(),
              2'($urandom_range(0, 3)), draw_element_value(), i == burst - 1));
          end
          made += burst;
        end
      endcase
    end
    n_items = pending_elements.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_items || expected_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d element transfers and %0d composed products (%0d elements),",
             n_accepted, n_computes, n_results);
    $display("including saturation both ways, dropped row-three writes and a long output hold.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
